/* hw/rtl/dtcf_pkg.sv */
`timescale 1ns / 1ps

package dtcf_pkg;

    // binary64 layout
    localparam int DBL_EXP_W  = 11;
    localparam int DBL_FRAC_W = 52;
    localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
    localparam logic [12:0] DBL_BIAS    = 13'd1023;

    // register reset values
    localparam logic [6:0] TOTAL_WIDTH_RST    = 7'd32;
    localparam logic [3:0] EXPONENT_WIDTH_RST = 4'd8;

    // legal register ranges
    localparam logic [6:0] TOTAL_WIDTH_MIN    = 7'd4;
    localparam logic [6:0] TOTAL_WIDTH_MAX    = 7'd64;
    localparam logic [3:0] EXPONENT_WIDTH_MIN = 4'd2;
    localparam logic [3:0] EXPONENT_WIDTH_MAX = 4'd11;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_TOTAL_WIDTH    = 1'b0,
        REG_EXPONENT_WIDTH = 1'b1
    } dtcf_reg_t;

    // target format, derived from the registers
    typedef struct packed {
        logic [5:0]  sign_pos;   // total width - 1
        logic [5:0]  frac_w;     // fraction bits, 1..61
        logic        wide;       // fraction 52 bits or wider, no rounding
        logic [5:0]  drop;       // dropped fraction bits when not wide
        logic [5:0]  pad;        // zero pad bits when wide
        logic [10:0] max_exp;    // all-ones exponent
        logic [9:0]  bias;
    } dtcf_fmt_t;

endpackage

/* hw/rtl/dtcf_cfg.sv */
`timescale 1ns / 1ps

module dtcf_cfg
    import dtcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output dtcf_fmt_t   fmt
);

    logic [6:0] total_width_reg;
    logic [3:0] exponent_width_reg;
    dtcf_fmt_t  fmt_reg;
    dtcf_fmt_t  fmt_next;
    dtcf_reg_t  reg_sel;
    logic       wr_en;

    logic [6:0] t_sat;
    logic [3:0] e_sat;
    logic [3:0] e_lim;
    logic [6:0] f_full;

    assign pready  = 1'b1;
    assign reg_sel = dtcf_reg_t'(paddr[2]);
    assign wr_en   = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_width_reg    <= TOTAL_WIDTH_RST;
            exponent_width_reg <= EXPONENT_WIDTH_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_TOTAL_WIDTH:    total_width_reg    <= pwdata[6:0];
                REG_EXPONENT_WIDTH: exponent_width_reg <= pwdata[3:0];
                default:            ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_TOTAL_WIDTH:    prdata = {25'd0, total_width_reg};
            REG_EXPONENT_WIDTH: prdata = {28'd0, exponent_width_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // clamp the widths and derive the format
    always_comb
    begin
        if (total_width_reg < TOTAL_WIDTH_MIN)
            t_sat = TOTAL_WIDTH_MIN;
        else if (total_width_reg > TOTAL_WIDTH_MAX)
            t_sat = TOTAL_WIDTH_MAX;
        else
            t_sat = total_width_reg;

        if (exponent_width_reg < EXPONENT_WIDTH_MIN)
            e_sat = EXPONENT_WIDTH_MIN;
        else if (exponent_width_reg > EXPONENT_WIDTH_MAX)
            e_sat = EXPONENT_WIDTH_MAX;
        else
            e_sat = exponent_width_reg;

        // keep at least one fraction bit
        if ({3'd0, e_sat} > (t_sat - 7'd2))
            e_lim = 4'(t_sat - 7'd2);
        else
            e_lim = e_sat;

        f_full = t_sat - {3'd0, e_lim} - 7'd1;

        fmt_next.sign_pos = 6'(t_sat - 7'd1);
        fmt_next.frac_w   = f_full[5:0];
        fmt_next.wide     = (f_full >= 7'(DBL_FRAC_W));
        fmt_next.drop     = fmt_next.wide ? 6'd1 : 6'(7'(DBL_FRAC_W) - f_full);
        fmt_next.pad      = fmt_next.wide ? 6'(f_full - 7'(DBL_FRAC_W)) : 6'd0;
        fmt_next.max_exp  = 11'((12'd1 << e_lim) - 12'd1);
        fmt_next.bias     = 10'((11'd1 << (e_lim - 4'd1)) - 11'd1);
    end

    // derived format register; the user must change widths only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= '0;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    assign fmt = fmt_reg;

endmodule

/* hw/rtl/dtcf_conv.sv */
`timescale 1ns / 1ps

module dtcf_conv
    import dtcf_pkg::*;
(
    input  logic [63:0] double_bits,
    input  dtcf_fmt_t   fmt,
    output logic [63:0] narrow_bits,
    output logic        overflowed
);

    logic                  sign;
    logic [DBL_EXP_W-1:0]  dexp;
    logic [DBL_FRAC_W-1:0] dfrac;
    logic [DBL_FRAC_W-1:0] trunc;
    logic                  rbit;
    logic [DBL_FRAC_W:0]   sum;
    logic                  carry;
    logic [63:0]           frac;
    logic [63:0]           nan_frac;
    logic signed [12:0]    texp;
    logic [63:0]           sign_field;
    logic [10:0]           exp_field;
    logic [63:0]           frac_field;

    assign sign  = double_bits[63];
    assign dexp  = double_bits[62:52];
    assign dfrac = double_bits[51:0];

    // cut and round half-up on the first dropped bit
    always_comb
    begin
        trunc = dfrac >> fmt.drop;
        rbit  = dfrac[fmt.drop - 6'd1];
        sum   = {1'b0, trunc} + {{DBL_FRAC_W{1'b0}}, rbit};
        carry = 1'b0;
        if (fmt.wide)
        begin
            frac = {12'd0, dfrac} << fmt.pad;
        end
        else
        begin
            carry = ((sum >> fmt.frac_w) != '0);
            frac  = carry ? 64'd0 : {11'd0, sum};
        end
        texp = $signed({2'b00, dexp}) - $signed(DBL_BIAS)
             + $signed({3'b000, fmt.bias}) + $signed({12'd0, carry});
    end

    // special cases and final assembly
    always_comb
    begin
        nan_frac   = 64'd1 << (fmt.frac_w - 6'd1);
        sign_field = {63'd0, sign} << fmt.sign_pos;
        exp_field  = 11'd0;
        frac_field = 64'd0;
        overflowed = 1'b0;
        if (dexp == DBL_EXP_MAX)
        begin
            exp_field  = fmt.max_exp;
            frac_field = (dfrac == '0) ? 64'd0 : nan_frac;
        end
        else if (dexp == '0)
        begin
            // zero and denormals flush to signed zero
        end
        else if (texp >= $signed({2'b00, fmt.max_exp}))
        begin
            exp_field  = fmt.max_exp;
            overflowed = 1'b1;
        end
        else if (texp <= 13'sd0)
        begin
            // underflow flushes to signed zero
        end
        else
        begin
            exp_field  = 11'(texp);
            frac_field = frac;
        end
        narrow_bits = sign_field | ({53'd0, exp_field} << fmt.frac_w) | frac_field;
    end

endmodule

/* hw/rtl/double_to_custom_float_core.sv */
`timescale 1ns / 1ps

// Converts the raw bit pattern of an IEEE binary64 value to a narrower float
// format (sign, exponent_width exponent bits, the rest fraction, right-aligned
// in 64 bits) with round half-up, overflow to infinity (overflow flag set),
// underflow and denormals flushed to signed zero, NaN to a quiet NaN. One beat
// is accepted per clock while the result stream is not stalled; each beat
// passes through the input register, then the result register behind the
// conversion logic.
// Registers: total_width at address 0x0, exponent_width at 0x4; write them
// only while no beat is in flight.
module double_to_custom_float_core
    import dtcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] double_bits
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] narrow_bits
    output logic        m_tuser,   // [0] overflowed
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dtcf_fmt_t   fmt;
    logic        in_valid_reg;
    logic [63:0] in_data_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_ovf_reg;
    logic [63:0] conv_bits;
    logic        conv_ovf;
    logic        out_load;

    dtcf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .fmt     (fmt)
    );

    dtcf_conv u_conv (
        .double_bits (in_data_reg),
        .fmt         (fmt),
        .narrow_bits (conv_bits),
        .overflowed  (conv_ovf)
    );

    // result register frees up when empty or taken this cycle
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= conv_bits;
            out_ovf_reg  <= conv_ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

/* sim/double_to_custom_float_core_tb.sv */
`timescale 1ns / 1ps

module double_to_custom_float_core_tb;

    import dtcf_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int STALL_LIMIT   = 2000;
    localparam int BEATS_PER_FMT = 62;
    localparam int FIXED_FMTS    = 12;
    localparam int RANDOM_FMTS   = 2;
    localparam int NUM_PROBES    = 22;

    // one converted value: what the result stream carries
    typedef struct packed {
        logic [63:0] narrow_bits;
        logic        overflowed;
    } narrow_res_t;

    // queued expectation, with its source double for reporting
    typedef struct packed {
        logic [63:0] src;
        narrow_res_t res;
    } pending_conv_t;

    // directed probe: pin = 1 means the result is typed in below
    typedef struct packed {
        logic [63:0] bits;
        logic        pin;
        logic [63:0] narrow_bits;
        logic        overflowed;
    } probe_row_t;

    // probes, run at the reset format (8-bit exponent, 23-bit fraction)
    localparam probe_row_t PROBES [0:NUM_PROBES-1] = '{
        '{64'h0000000000000000, 1'b1, 64'h0000000000000000, 1'b0}, // +0
        '{64'h8000000000000000, 1'b1, 64'h0000000080000000, 1'b0}, // -0
        '{64'h3FF0000000000000, 1'b1, 64'h000000003F800000, 1'b0}, // 1.0
        '{64'hC000000000000000, 1'b1, 64'h00000000C0000000, 1'b0}, // -2.0
        '{64'h7FF0000000000000, 1'b1, 64'h000000007F800000, 1'b0}, // +inf
        '{64'hFFF0000000000000, 1'b1, 64'h00000000FF800000, 1'b0}, // -inf
        '{64'h7FF8000000000000, 1'b1, 64'h000000007FC00000, 1'b0}, // quiet NaN
        '{64'hFFF0000000000001, 1'b1, 64'h00000000FFC00000, 1'b0}, // signaling NaN
        '{64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h00000000FFC00000, 1'b0}, // all ones
        '{64'h7FEFFFFFFFFFFFFF, 1'b1, 64'h000000007F800000, 1'b1}, // max double
        '{64'hFFEFFFFFFFFFFFFF, 1'b1, 64'h00000000FF800000, 1'b1}, // -max double
        '{64'h0000000000000001, 1'b1, 64'h0000000000000000, 1'b0}, // min denormal
        '{64'h800FFFFFFFFFFFFF, 1'b1, 64'h0000000080000000, 1'b0}, // -max denormal
        '{64'h0010000000000000, 1'b1, 64'h0000000000000000, 1'b0}, // min normal
        '{64'h3FFFFFFFFFFFFFFF, 1'b0, 64'h0, 1'b0}, // carry into exponent
        '{64'h3FF0000010000000, 1'b0, 64'h0, 1'b0}, // exactly half, rounds up
        '{64'h3FF000000FFFFFFF, 1'b0, 64'h0, 1'b0}, // just below half
        '{64'h47EFFFFFF0000000, 1'b0, 64'h0, 1'b0}, // carry pushes to overflow
        '{64'h47EFFFFFE0000000, 1'b0, 64'h0, 1'b0}, // largest normal
        '{64'h3810000000000000, 1'b0, 64'h0, 1'b0}, // smallest normal
        '{64'h380FFFFFFFFFFFFF, 1'b0, 64'h0, 1'b0}, // carry out of underflow
        '{64'h3800000000000000, 1'b0, 64'h0, 1'b0}  // just underflows
    };

    // formats after reset, extremes and out-of-range values first
    localparam int FMT_TOTAL [0:FIXED_FMTS-1] =
        '{64, 4, 64, 4, 0, 127, 16, 60, 10, 53, 24, 33};
    localparam int FMT_EXP   [0:FIXED_FMTS-1] =
        '{11, 2, 2, 11, 0, 15, 5, 3, 9, 11, 4, 1};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] double_bits
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] narrow_bits
    logic        m_tuser;   // [0] overflowed
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the format registers
    logic [6:0]  cfg_total;
    logic [3:0]  cfg_exp;

    pending_conv_t expected_narrow [$];
    logic        pin_valid;
    narrow_res_t pinned_res;
    logic        no_idle;
    int          mismatches;
    int          doubles_in;
    int          overflows_seen;
    int          formats_used;
    int          idle_cycles;

    double_to_custom_float_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // effective target widths after saturation
    function automatic void target_widths(output int t, output int e, output int f);
        t = int'(cfg_total);
        e = int'(cfg_exp);
        if (t < int'(TOTAL_WIDTH_MIN)) t = int'(TOTAL_WIDTH_MIN);
        if (t > int'(TOTAL_WIDTH_MAX)) t = int'(TOTAL_WIDTH_MAX);
        if (e < int'(EXPONENT_WIDTH_MIN)) e = int'(EXPONENT_WIDTH_MIN);
        if (e > int'(EXPONENT_WIDTH_MAX)) e = int'(EXPONENT_WIDTH_MAX);
        if (e > t - 2) e = t - 2;
        f = t - e - 1;
    endfunction

    // double -> narrow float, round half-up, flush to zero below normal
    function automatic narrow_res_t predict_narrow(input logic [63:0] bits);
        int          t;
        int          e;
        int          f;
        int          texp;
        int          tbias;
        int          drop;
        logic [10:0] dexp;
        logic [63:0] dfrac;
        logic [63:0] frac;
        logic [63:0] maxexp;
        logic [63:0] sign_word;
        narrow_res_t r;
        target_widths(t, e, f);
        dexp      = bits[62:52];
        dfrac     = {12'd0, bits[51:0]};
        maxexp    = (64'd1 << e) - 64'd1;
        tbias     = (1 << (e - 1)) - 1;
        sign_word = {63'd0, bits[63]} << (t - 1);
        r.overflowed = 1'b0;
        if (dexp == DBL_EXP_MAX)
        begin
            frac = (dfrac == 64'd0) ? 64'd0 : (64'd1 << (f - 1));
            r.narrow_bits = sign_word | (maxexp << f) | frac;
        end
        else if (dexp == 11'd0)
        begin
            r.narrow_bits = sign_word;
        end
        else
        begin
            texp = int'(dexp) - int'(DBL_BIAS);
            if (f >= DBL_FRAC_W)
            begin
                frac = dfrac << (f - DBL_FRAC_W);
            end
            else
            begin
                drop = DBL_FRAC_W - f;
                frac = (dfrac >> drop) + ((dfrac >> (drop - 1)) & 64'd1);
                if (frac == (64'd1 << f))
                begin
                    frac = 64'd0;
                    texp++;
                end
            end
            texp += tbias;
            if (texp >= int'(maxexp))
            begin
                r.narrow_bits = sign_word | (maxexp << f);
                r.overflowed  = 1'b1;
            end
            else if (texp <= 0)
            begin
                r.narrow_bits = sign_word;
            end
            else
            begin
                r.narrow_bits = sign_word | (64'(texp) << f) | frac;
            end
        end
        return r;
    endfunction

    // random double, biased toward the current format's exponent range
    function automatic logic [63:0] pick_double();
        int          t;
        int          e;
        int          f;
        int          tbias;
        int          x;
        int          k;
        logic [63:0] rnd;
        logic [63:0] mask;
        logic [10:0] dexp;
        logic [51:0] dfrac;
        target_widths(t, e, f);
        tbias = (1 << (e - 1)) - 1;
        rnd   = {$urandom, $urandom};
        dfrac = rnd[51:0];
        case ($urandom_range(0, 9))
            0, 1:
            begin
                return rnd;
            end
            2:
            begin
                dexp = DBL_EXP_MAX;
                if ($urandom_range(0, 3) == 0) dfrac = '0;
            end
            3:
            begin
                dexp = 11'd0;
                if ($urandom_range(0, 3) == 0) dfrac = '0;
            end
            default:
            begin
                // around both ends of the target exponent range
                x = int'(DBL_BIAS) + $urandom_range(0, 2 * tbias + 6) - (tbias + 3);
                if (x < 1) x = 1;
                if (x > 2046) x = 2046;
                dexp = x[10:0];
                if ($urandom_range(0, 2) == 0)
                begin
                    // long run of ones to provoke a rounding carry
                    k     = $urandom_range(0, 52);
                    mask  = (64'd1 << k) - 64'd1;
                    dfrac = ~mask[51:0] | (rnd[51:0] & mask[51:0]);
                end
            end
        endcase
        return {$urandom_range(0, 1) == 1, dexp, dfrac};
    endfunction

    // one beat on the input stream, with an optional gap in front
    task automatic send_double(input logic [63:0] bits, input logic pin,
                               input narrow_res_t res);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= bits;
        pin_valid  = pin;
        pinned_res = res;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and let every pending result come back
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        pin_valid = 1'b0;
        while (expected_narrow.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic apb_write(input dtcf_reg_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input dtcf_reg_t idx, output logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        val = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // program a format and read it back
    task automatic set_format(input logic [6:0] tw, input logic [3:0] ew);
        logic [31:0] rd;
        apb_write(REG_TOTAL_WIDTH, {25'd0, tw});
        apb_write(REG_EXPONENT_WIDTH, {28'd0, ew});
        cfg_total = tw;
        cfg_exp   = ew;
        formats_used++;
        apb_read(REG_TOTAL_WIDTH, rd);
        if (rd !== {25'd0, tw})
        begin
            $display("%0t: total_width readback expected %h actual %h", $time, tw, rd);
            mismatches++;
        end
        apb_read(REG_EXPONENT_WIDTH, rd);
        if (rd !== {28'd0, ew})
        begin
            $display("%0t: exponent_width readback expected %h actual %h", $time, ew, rd);
            mismatches++;
        end
    endtask

    // scoreboard: expectations queued on input beats, checked on result beats
    always @(posedge clk)
    begin : scoreboard
        pending_conv_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            want.src = s_tdata;
            want.res = pin_valid ? pinned_res : predict_narrow(s_tdata);
            expected_narrow.push_back(want);
            doubles_in++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser === 1'b1) overflows_seen++;
            if (expected_narrow.size() == 0)
            begin
                $display("%0t: unexpected result beat narrow_bits %h overflowed %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_narrow.pop_front();
                if (m_tdata !== want.res.narrow_bits)
                begin
                    $display("%0t: double %h narrow_bits expected %h actual %h",
                             $time, want.src, want.res.narrow_bits, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.res.overflowed)
                begin
                    $display("%0t: double %h overflowed expected %b actual %b",
                             $time, want.src, want.res.overflowed, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d results pending",
                     idle_cycles, expected_narrow.size());
            $display("double_to_custom_float_core_tb NOT OK");
            $finish;
        end
    end

    // result-side back-pressure in random bursts
    initial
    begin : sink_stall
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                hold     = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        narrow_res_t r;
        int          nfmt;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 64'd0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 3'd0;
        pwdata         = 32'd0;
        pin_valid      = 1'b0;
        pinned_res     = '0;
        no_idle        = 1'b0;
        mismatches     = 0;
        doubles_in     = 0;
        overflows_seen = 0;
        formats_used   = 1;
        idle_cycles    = 0;
        cfg_total      = TOTAL_WIDTH_RST;
        cfg_exp        = EXPONENT_WIDTH_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed probes at the reset format
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            r.narrow_bits = PROBES[i].narrow_bits;
            r.overflowed  = PROBES[i].overflowed;
            send_double(PROBES[i].bits, PROBES[i].pin, r);
        end
        for (int j = 0; j < BEATS_PER_FMT; j++)
            send_double(pick_double(), 1'b0, '0);

        // fixed formats, then random ones; the last runs without idling
        nfmt = FIXED_FMTS + RANDOM_FMTS;
        for (int p = 0; p < nfmt; p++)
        begin
            drain_results();
            if (p < FIXED_FMTS)
                set_format(FMT_TOTAL[p][6:0], FMT_EXP[p][3:0]);
            else
                set_format(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
            no_idle = (p == nfmt - 1) || ($urandom_range(0, 3) == 0);
            for (int j = 0; j < BEATS_PER_FMT; j++)
                send_double(pick_double(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (expected_narrow.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);

        $display("converted %0d doubles across %0d target formats, %0d overflowed",
                 doubles_in, formats_used, overflows_seen);
        if (mismatches == 0)
            $display("double_to_custom_float_core_tb OK");
        else
            $display("double_to_custom_float_core_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dtcf_pkg.sv
hw/rtl/dtcf_cfg.sv
hw/rtl/dtcf_conv.sv
hw/rtl/double_to_custom_float_core.sv
sim/double_to_custom_float_core_tb.sv
